>>> hw/rtl/nfa_pkg.sv
// Package for the NFA matcher: request and node kind codes, widths, FSM state type.
// No dependencies.
package nfa_pkg;
    localparam int NODE_COUNT_DEF = 64;
    localparam int IDX_W = 6;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_CHAR = 2'd1,
        REQ_END  = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_JUMP    = 2'd0,
        KIND_CONSUME = 2'd1,
        KIND_SPLIT   = 2'd2,
        KIND_MATCH   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_POP,
        ST_EXEC,
        ST_PUSHB,
        ST_DONE
    } t_state;
endpackage

>>> hw/rtl/nfa_if.sv
// Valid/ready channel interfaces for the NFA matcher.
// Depends on nothing.
interface nfa_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [5:0] entry_index;
    logic [1:0] entry_kind;
    logic [7:0] entry_char;
    logic [5:0] entry_next_a;
    logic [5:0] entry_next_b;
    logic [7:0] symbol;
    modport source (output valid, req_type, entry_index, entry_kind, entry_char,
                    entry_next_a, entry_next_b, symbol, input ready);
    modport sink (input valid, req_type, entry_index, entry_kind, entry_char,
                  entry_next_a, entry_next_b, symbol, output ready);
endinterface

interface nfa_out_if;
    logic valid;
    logic ready;
    logic matched;
    modport source (output valid, matched, input ready);
    modport sink (input valid, matched, output ready);
endinterface

interface nfa_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> hw/rtl/nfa_regex_matcher.sv
// Thompson NFA whole-string matcher. Load beats write the node table without leaving idle. Character
// and end beats: a scan of the active set seeds the walk stack, then each expanded node passes the pop,
// table read and push steps, plus a detour step per split second branch, then a done step returns to
// idle; no new beat is taken until the walk is through. The node table has a single read port.
// An end result waiting in the output register holds the input.
// Reset (synchronous, active low) clears start node to 0 and activates only node 0;
// the node table needs no clearing pass.
module nfa_regex_matcher #(
    parameter int NODE_COUNT = nfa_pkg::NODE_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nfa_in_if.sink     in_ch,
    nfa_cfg_if.sink    cfg_ch,
    nfa_out_if.source  out_ch
);
    import nfa_pkg::*;
    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int DW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT + 1) : 1;

    // Node table: kind, char, next_a, next_b.
    logic [21:0] node_mem [NODE_COUNT];
    logic [AW-1:0] stack_mem [NODE_COUNT];

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_start;
    logic [NODE_COUNT-1:0] r_active, r_visited, r_next;
    logic [DW-1:0] r_depth;
    logic [AW:0] r_scan;
    logic r_is_char, r_found;
    logic [7:0] r_sym;
    logic [5:0] r_nb;
    logic [21:0] r_rd;
    logic [AW-1:0] r_stk_rd;
    logic r_out_valid, r_out_m;

    // Stack push/pop and table read controls from the FSM.
    logic push_en;
    logic [AW-1:0] push_val;
    logic pop_en, tbl_rd_en, done_beat;

    logic in_fire, cfg_fire, idle, out_free;
    assign idle     = (r_state == ST_IDLE);
    assign out_free = !r_out_valid || out_ch.ready;
    assign in_ch.ready  = idle && out_free;
    assign cfg_ch.ready = idle;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
    assign out_ch.valid   = r_out_valid;
    assign out_ch.matched = r_out_m;

    // Successor visit test: in range and not yet seen.
    function automatic logic can_visit(input logic [5:0] n, input logic [NODE_COUNT-1:0] v);
        logic ok;
        ok = (32'(n) < NODE_COUNT);
        if (ok) ok = !v[n[AW-1:0]];
        return ok;
    endfunction

    // Active set holding only the given node, empty when it names no node.
    function automatic logic [NODE_COUNT-1:0] start_set(input logic [IDX_W-1:0] n);
        logic [NODE_COUNT-1:0] s;
        s = '0;
        if (32'(n) < NODE_COUNT) s[n[AW-1:0]] = 1'b1;
        return s;
    endfunction

    logic [1:0] ex_kind;
    logic [7:0] ex_ch;
    logic [5:0] ex_a, ex_b;
    assign {ex_kind, ex_ch, ex_a, ex_b} = r_rd;
    logic scan_hit;
    assign scan_hit = (r_scan < (AW+1)'(NODE_COUNT)) && r_active[r_scan[AW-1:0]];

    // Next state and stack control.
    always_comb begin
        n_state = r_state;
        push_en = 1'b0;
        push_val = '0;
        pop_en = 1'b0;
        tbl_rd_en = 1'b0;
        done_beat = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && (in_ch.req_type == REQ_CHAR || in_ch.req_type == REQ_END))
                    n_state = ST_SEED;
            end
            ST_SEED: begin
                if (r_scan >= (AW+1)'(NODE_COUNT)) n_state = ST_POP;
                else if (scan_hit) begin
                    push_en = 1'b1;
                    push_val = r_scan[AW-1:0];
                end
            end
            ST_POP: begin
                if (r_depth == '0) n_state = ST_DONE;
                else begin
                    pop_en = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Stack output valid this cycle; table data arrives next.
                tbl_rd_en = 1'b1;
                n_state = ST_PUSHB;
            end
            ST_PUSHB: begin
                n_state = ST_POP;
                case (t_kind'(ex_kind))
                    KIND_JUMP: if (can_visit(ex_a, r_visited)) begin
                        push_en = 1'b1; push_val = ex_a[AW-1:0];
                    end
                    KIND_SPLIT: begin
                        if (can_visit(ex_a, r_visited)) begin
                            push_en = 1'b1; push_val = ex_a[AW-1:0];
                        end
                        n_state = ST_SEED; // reuse as "push next_b" via the r_pend_b detour
                    end
                    default: ;
                endcase
            end
            ST_DONE: begin
                done_beat = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Split second branch: handled by a one-cycle detour flag.
    logic r_pend_b;

    // Memories.
    always_ff @(posedge i_clk) begin
        if (in_fire && in_ch.req_type == REQ_LOAD && 32'(in_ch.entry_index) < NODE_COUNT)
            node_mem[in_ch.entry_index[AW-1:0]] <= {in_ch.entry_kind, in_ch.entry_char,
                                                   in_ch.entry_next_a, in_ch.entry_next_b};
        if (tbl_rd_en) r_rd <= node_mem[r_stk_rd];
    end
    logic do_push_b;
    assign do_push_b = r_pend_b && can_visit(r_nb, r_visited);
    logic [DW-1:0] push_addr;
    assign push_addr = r_depth;
    always_ff @(posedge i_clk) begin
        if (push_en && !r_pend_b) stack_mem[push_addr[AW-1:0]] <= push_val;
        else if (do_push_b) stack_mem[push_addr[AW-1:0]] <= r_nb[AW-1:0];
        if (pop_en) r_stk_rd <= stack_mem[r_depth[AW-1:0] - AW'(1)];
    end

    // Control and set registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= '0;
            r_active <= start_set('0);
            r_out_valid <= 1'b0;
            r_pend_b <= 1'b0;
            r_depth <= '0;
        end else begin
            // The end result is loaded when the walk finishes and held until taken.
            if (done_beat && !r_is_char) r_out_valid <= 1'b1;
            else if (out_ch.ready) r_out_valid <= 1'b0;
            if (cfg_fire) begin
                r_start <= cfg_ch.data;
                r_active <= start_set(cfg_ch.data);
            end
            if (in_fire && (in_ch.req_type == REQ_CHAR || in_ch.req_type == REQ_END)) begin
                r_is_char <= (in_ch.req_type == REQ_CHAR);
                r_sym <= in_ch.symbol;
                r_found <= 1'b0;
                r_visited <= '0;
                r_next <= '0;
                r_scan <= '0;
                r_depth <= '0;
            end
            if (r_pend_b) begin
                // Detour cycle: push the split's second branch, then resume popping.
                r_pend_b <= 1'b0;
                r_state <= ST_POP;
                if (do_push_b) begin
                    r_visited[r_nb[AW-1:0]] <= 1'b1;
                    r_depth <= r_depth + DW'(1);
                end
            end else begin
                r_state <= n_state;
                if (r_state == ST_SEED && !(r_scan >= (AW+1)'(NODE_COUNT)))
                    r_scan <= r_scan + (AW+1)'(1);
                if (push_en) begin
                    r_visited[push_val] <= 1'b1;
                    r_depth <= r_depth + DW'(1);
                end
                if (pop_en) r_depth <= r_depth - DW'(1);
                if (r_state == ST_PUSHB) begin
                    if (t_kind'(ex_kind) == KIND_SPLIT) begin
                        r_pend_b <= 1'b1;
                        r_nb <= ex_b;
                    end
                    if (t_kind'(ex_kind) == KIND_CONSUME && r_is_char && ex_ch == r_sym
                        && 32'(ex_a) < NODE_COUNT)
                        r_next[ex_a[AW-1:0]] <= 1'b1;
                    if (t_kind'(ex_kind) == KIND_MATCH && !r_is_char) r_found <= 1'b1;
                end
                if (done_beat) begin
                    if (r_is_char) r_active <= r_next;
                    else begin
                        r_out_m <= r_found;
                        r_active <= start_set(r_start);
                    end
                end
            end
        end
    end

    // Checks.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_b |=> !r_pend_b) else $error("split detour lasted two cycles");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && !r_is_char |=> r_out_valid) else $error("end result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= NODE_COUNT) else $error("walk stack overflow");
endmodule

>>> verif/tb_nfa_regex_matcher.sv
// Testbench for the NFA matcher: loads automata, streams strings and end beats,
// and checks each match flag against an in-bench closure walk. Needs nfa_pkg, nfa_if.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nfa_pkg::*;

    localparam int NODES = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [5:0] next_a;
        logic [5:0] next_b;
    } t_node;

    logic i_clk;
    logic i_rst_n;

    nfa_in_if  in_ch();
    nfa_out_if out_ch();
    nfa_cfg_if cfg_ch();

    nfa_regex_matcher DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink), .cfg_ch(cfg_ch.sink), .out_ch(out_ch.source)
    );

    // Predictor state.
    t_node       node_mem [NODES];
    logic [63:0] live_nodes;
    logic [5:0]  entry_node;
    bit          flag_queue [$];

    int errors = 0;
    int flags_seen = 0;
    int beats_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 0;
    int idle_cycles = 0;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Epsilon closure of the live set; builds the next live set on a character.
    function automatic bit walk_closure(input bit is_char, input logic [7:0] sym,
                                        output logic [63:0] next_live);
        logic [63:0] seen;
        int stack [$];
        int n;
        bit found;
        t_node e;
        seen = live_nodes;
        next_live = '0;
        found = 0;
        for (int i = 0; i < NODES; i++)
            if (live_nodes[i]) stack.push_back(i);
        while (stack.size() > 0) begin
            n = stack.pop_back();
            e = node_mem[n];
            case (e.kind)
                KIND_JUMP: begin
                    if (!seen[e.next_a]) begin
                        seen[e.next_a] = 1;
                        stack.push_back(int'(e.next_a));
                    end
                end
                KIND_CONSUME: begin
                    if (is_char && e.ch == sym) next_live[e.next_a] = 1;
                end
                KIND_SPLIT: begin
                    if (!seen[e.next_a]) begin
                        seen[e.next_a] = 1;
                        stack.push_back(int'(e.next_a));
                    end
                    if (!seen[e.next_b]) begin
                        seen[e.next_b] = 1;
                        stack.push_back(int'(e.next_b));
                    end
                end
                default: begin
                    if (!is_char) found = 1;
                end
            endcase
        end
        return found;
    endfunction

    // Apply one accepted beat to the predictor.
    function automatic void predict_beat(input t_req req, input t_node e,
                                         input logic [5:0] idx, input logic [7:0] sym);
        logic [63:0] nxt;
        case (req)
            REQ_LOAD: node_mem[idx] = e;
            REQ_CHAR: begin
                void'(walk_closure(1, sym, nxt));
                live_nodes = nxt;
            end
            REQ_END: begin
                flag_queue.push_back(walk_closure(0, 8'd0, nxt));
                live_nodes = 64'd1 << entry_node;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Send one beat, idling at random before it. Valid stays high after the
    // beat so that the next one can follow at once; drain drops it.
    task automatic send_beat(input t_req req, input logic [5:0] idx, input t_node e,
                             input logic [7:0] sym);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.req_type <= req;
        in_ch.entry_index <= idx;
        in_ch.entry_kind <= e.kind;
        in_ch.entry_char <= e.ch;
        in_ch.entry_next_a <= e.next_a;
        in_ch.entry_next_b <= e.next_b;
        in_ch.symbol <= sym;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_beat(req, e, idx, sym);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_node(input int idx, input t_kind k, input int ch,
                             input int a, input int b);
        t_node e;
        e.kind = k; e.ch = 8'(ch); e.next_a = 6'(a); e.next_b = 6'(b);
        send_beat(REQ_LOAD, 6'(idx), e, 8'($urandom));
    endtask

    task automatic send_char(input logic [7:0] c);
        t_node e;
        e = t_node'(22'($urandom));
        send_beat(REQ_CHAR, 6'($urandom), e, c);
    endtask

    task automatic send_end();
        t_node e;
        e = t_node'(22'($urandom));
        send_beat(REQ_END, 6'($urandom), e, 8'($urandom));
    endtask

    // Wait for every expected flag, then let the block settle before a register write.
    task automatic drain();
        int guard;
        guard = 0;
        in_ch.valid <= 0;
        while (flag_queue.size() > 0 && guard < 100000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (3 * NODES + 20) @(negedge i_clk);
    endtask

    task automatic write_start(input logic [5:0] s);
        drain();
        cfg_ch.valid <= 1;
        cfg_ch.data <= s;
        do @(posedge i_clk); while (!cfg_ch.ready);
        entry_node = s;
        live_nodes = 64'd1 << s;
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    // Fill the whole table with random nodes so no read ever hits an unwritten slot.
    task automatic load_random_table(input int alphabet);
        for (int i = 0; i < NODES; i++)
            load_node(i, t_kind'(2'($urandom_range(3))), $urandom_range(alphabet - 1),
                      $urandom_range(NODES - 1), $urandom_range(NODES - 1));
    endtask

    // Directed: an a(b|c)*d automaton at both ends of the index range, plus extremes.
    task automatic test_directed();
        // 63:a->62, 62:split 61/59, 61:split 60/58, 60:b->62, 58:c->62, 59:d->57, 57 match
        load_node(63, KIND_CONSUME, "a", 62, 0);
        load_node(62, KIND_SPLIT, 0, 61, 59);
        load_node(61, KIND_SPLIT, 0, 60, 58);
        load_node(60, KIND_CONSUME, "b", 62, 0);
        load_node(58, KIND_CONSUME, "c", 62, 0);
        load_node(59, KIND_CONSUME, "d", 57, 0);
        load_node(57, KIND_MATCH, 8'hFF, 57, 63);
        load_node(0, KIND_JUMP, 0, 63, 0);
        write_start(6'd63);
        send_char("a"); send_char("b"); send_char("c"); send_char("d"); send_end();
        send_char("a"); send_char("x"); send_end();
        send_end();
        send_char("a"); send_char("d"); send_char("d"); send_end();
        // Start through the jump at node 0, plus a request with no meaning.
        write_start(6'd0);
        send_beat(REQ_NONE, 6'd1, '1, 8'hFF);
        send_char("a"); send_char("d"); send_end();
        load_node(1, KIND_CONSUME, 8'hFF, 57, 0);
        load_node(0, KIND_SPLIT, 0, 1, 63);
        send_char(8'hFF); send_end();
    endtask

    // Random strings over a small alphabet on random tables, with some loads mixed in.
    task automatic test_random(input int beats);
        int sent;
        sent = 0;
        while (sent < beats) begin
            if (sent == 0 || $urandom_range(9) == 0) begin
                load_random_table(4);
                write_start(6'($urandom));
                sent += NODES;
            end
            repeat ($urandom_range(6)) begin
                if ($urandom_range(19) == 0)
                    load_node($urandom, t_kind'(2'($urandom_range(3))), $urandom_range(3),
                              $urandom, $urandom);
                else
                    send_char(8'($urandom_range(15) == 0 ? $urandom : $urandom_range(3)));
                sent++;
            end
            send_end();
            sent++;
        end
    endtask

    // Receiver stops for a long stretch while ends keep arriving.
    task automatic test_backpressure();
        hold_off = 1;
        repeat (12) send_end();
        hold_off = 0;
    endtask

    // Receiver ready, with a long hold-off counted here.
    initial begin
        int stall_left;
        bit was_held;
        stall_left = 0;
        was_held = 0;
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            // One long stall when the hold-off begins.
            if (hold_off && !was_held) stall_left = 3000;
            was_held = hold_off;
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            flags_seen++;
            if (flag_queue.size() == 0)
                report_mismatch("match flag with nothing expected");
            else if (out_ch.matched !== flag_queue.pop_front())
                report_mismatch($sformatf("matched is %b, wrong", out_ch.matched));
        end
    end

    // Watchdog on cycles without any accepted beat while a beat or flag is pending.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !in_ch.valid && flag_queue.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d flags pending", flag_queue.size());
            $display("nfa_regex_matcher test failed");
            $finish;
        end
    end

    // Sequence of tests.
    initial begin
        in_ch.valid = 0;
        in_ch.req_type = REQ_NONE;
        in_ch.entry_index = '0;
        in_ch.entry_kind = KIND_JUMP;
        in_ch.entry_char = '0;
        in_ch.entry_next_a = '0;
        in_ch.entry_next_b = '0;
        in_ch.symbol = '0;
        cfg_ch.valid = 0;
        cfg_ch.data = '0;
        for (int i = 0; i < NODES; i++) node_mem[i] = '0;
        entry_node = '0;
        live_nodes = 64'd1;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        test_directed();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(500);
        send_idle_pct = 79; recv_stall_pct = 0;  test_random(500);
        send_idle_pct = 0;  recv_stall_pct = 79; test_random(500);
        send_idle_pct = 23; recv_stall_pct = 23; test_random(500);
        send_idle_pct = 0;  recv_stall_pct = 0;  test_backpressure();

        drain();
        $display("Sent %0d beats and checked %0d match flags over random automata,",
                 beats_sent, flags_seen);
        $display("with varied start nodes, idle and stall phases and a long hold-off.");
        if (errors == 0 && flag_queue.size() == 0) begin
            $display("nfa_regex_matcher test passed");
        end else begin
            $display("%0d mismatches, %0d flags never came", errors, flag_queue.size());
            $display("nfa_regex_matcher test failed");
        end
        $finish;
    end
endmodule
